### sv/parametric_line_rasterizer_unit_assert.svh
// Assertion helpers for the line rasterizer. Each check samples on clk_i and
// is held off while rst_ni is low.
`ifndef PARAMETRIC_LINE_RASTERIZER_UNIT_ASSERT_SVH
`define PARAMETRIC_LINE_RASTERIZER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define PLR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("plr same-cycle check failed");
`define PLR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("plr next-cycle check failed");
`else
`define PLR_ASSERT_SAME(lbl, ante, cons)
`define PLR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### sv/plr_pkg.sv
package plr_pkg;

  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned DELTA_BITS = COORD_BITS + 1;
  localparam int unsigned SQ_BITS    = 2 * COORD_BITS + 2;
  localparam int unsigned ACC_BITS   = 2 * COORD_BITS + 3;
  localparam int unsigned ITERS      = COORD_BITS + 1;
  localparam int unsigned CNT_BITS   = $clog2(ITERS);
  localparam int unsigned RGB_BITS   = 24;
  localparam int unsigned CFG_BITS   = 13;

  localparam logic [CFG_BITS-1:0] SURF_WIDTH_RST  = CFG_BITS'(640);
  localparam logic [CFG_BITS-1:0] SURF_HEIGHT_RST = CFG_BITS'(480);

  typedef enum logic {
    CFG_SURF_WIDTH  = 1'b0,
    CFG_SURF_HEIGHT = 1'b1
  } cfg_addr_e;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_STEP = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_SUM,
    S_ROOT,
    S_FIX,
    S_DIV,
    S_EMIT
  } plr_state_e;

  typedef struct packed {
    logic                          func;
    logic signed [COORD_BITS-1:0]  x_start;
    logic signed [COORD_BITS-1:0]  y_start;
    logic signed [COORD_BITS-1:0]  x_end;
    logic signed [COORD_BITS-1:0]  y_end;
    logic [RGB_BITS-1:0]           rgb;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0]  pixel_x;
    logic signed [COORD_BITS-1:0]  pixel_y;
    logic [RGB_BITS-1:0]           pixel_rgb;
    logic                          inside_res;
    logic                          last;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic square;
    logic sum;
    logic root_step;
    logic root_fix;
    logic div_start;
    logic div_step;
    logic emit;
  } plr_cmd_t;

  typedef struct packed {
    logic busy;
  } plr_status_t;

endpackage

### sv/plr_div.sv
module plr_div (
  input  logic                          clk_i,
  input  logic                          start_i,
  input  logic                          step_i,
  input  logic [plr_pkg::SQ_BITS-1:0]    dividend_i,
  input  logic [plr_pkg::DELTA_BITS-1:0] divisor_i,
  output logic [plr_pkg::DELTA_BITS-1:0] quotient_o
);
  import plr_pkg::*;

  // Restoring division, one quotient bit a cycle. The dividend is known to be
  // below divisor * 2^DELTA_BITS, so the upper half starts as the remainder.
  logic [DELTA_BITS-1:0] rem_q, rem_d;
  logic [DELTA_BITS-1:0] lo_q, lo_d;
  logic [DELTA_BITS:0]   rem_sh;
  logic [DELTA_BITS:0]   rem_sub;
  logic                  fits;

  assign rem_sh  = {rem_q, lo_q[DELTA_BITS-1]};
  assign fits    = rem_sh >= {1'b0, divisor_i};
  assign rem_sub = rem_sh - {1'b0, divisor_i};

  always_comb begin
    rem_d = rem_q;
    lo_d  = lo_q;
    if (start_i) begin
      rem_d = dividend_i[SQ_BITS-1:DELTA_BITS];
      lo_d  = dividend_i[DELTA_BITS-1:0];
    end else if (step_i) begin
      rem_d = fits ? rem_sub[DELTA_BITS-1:0] : rem_sh[DELTA_BITS-1:0];
      lo_d  = {lo_q[DELTA_BITS-2:0], fits};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
  end

  assign quotient_o = lo_q;

endmodule

### sv/plr_ctrl.sv
module plr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_func_i,
  input  logic                 out_ready_i,
  input  plr_pkg::plr_status_t status_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  output plr_pkg::plr_cmd_t    cmd_o
);
  import plr_pkg::*;

  plr_state_e          state_q, state_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic                accept;
  logic                cnt_last;
  logic                slot_free;

  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign cnt_last  = cnt_q == CNT_BITS'(ITERS - 1);
  assign slot_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_func_i == FUNC_LOAD) begin
            state_d = S_SQUARE;
          end else if (status_i.busy) begin
            state_d = S_DIV;
          end
        end
      end
      S_SQUARE: state_d = S_SUM;
      S_SUM:    state_d = S_ROOT;
      S_ROOT: begin
        if (cnt_last) state_d = S_FIX;
      end
      S_FIX:    state_d = S_IDLE;
      S_DIV: begin
        if (cnt_last) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o       = 1'b1;
        cmd_o.load       = accept && (in_func_i == FUNC_LOAD);
        cmd_o.div_start  = accept && (in_func_i == FUNC_STEP) && status_i.busy;
      end
      S_SQUARE: cmd_o.square    = 1'b1;
      S_SUM:    cmd_o.sum       = 1'b1;
      S_ROOT:   cmd_o.root_step = 1'b1;
      S_FIX:    cmd_o.root_fix  = 1'b1;
      S_DIV:    cmd_o.div_step  = 1'b1;
      S_EMIT:   cmd_o.emit      = slot_free;
      default:  cmd_o           = '0;
    endcase
  end

  always_comb begin
    cnt_d = '0;
    if (state_q == S_ROOT || state_q == S_DIV) begin
      cnt_d = CNT_BITS'(cnt_q + 1'b1);
    end
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### sv/plr_dp.sv
module plr_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  plr_pkg::plr_cmd_t           cmd_i,
  output plr_pkg::plr_status_t        status_o,
  input  plr_pkg::in_word_t           in_word_i,
  input  logic                        cfg_we_i,
  input  logic                        cfg_addr_i,
  input  logic [plr_pkg::CFG_BITS-1:0] cfg_wdata_i,
  output plr_pkg::out_word_t          out_word_o
);
  import plr_pkg::*;

  localparam int unsigned PX_BITS  = DELTA_BITS + 1;
  localparam int unsigned CMP_BITS = (PX_BITS > CFG_BITS) ? PX_BITS : CFG_BITS;

  logic signed [COORD_BITS-1:0] origin_x_q, origin_y_q;
  logic signed [DELTA_BITS-1:0] delta_x_q, delta_y_q;
  logic [DELTA_BITS-1:0]        step_total_q, step_index_q;
  logic [RGB_BITS-1:0]          held_rgb_q;
  logic signed [ACC_BITS-1:0]   acc_x_q, acc_y_q;
  logic [SQ_BITS-1:0]           sq_x_q, sq_y_q, rad_q;
  logic [DELTA_BITS-1:0]        root_q;
  logic [DELTA_BITS:0]          rem_q;
  logic [CFG_BITS-1:0]          surf_width_q, surf_height_q;
  logic                         busy_q, busy_d;
  out_word_t                    out_word_q;

  // load: endpoint differences
  logic signed [DELTA_BITS-1:0] dx_load, dy_load;
  assign dx_load = DELTA_BITS'(in_word_i.x_end) - DELTA_BITS'(in_word_i.x_start);
  assign dy_load = DELTA_BITS'(in_word_i.y_end) - DELTA_BITS'(in_word_i.y_start);

  // square root, two radicand bits a cycle
  logic [DELTA_BITS+2:0] rem_sh, trial, rem_sub;
  logic                  root_ok;
  logic [DELTA_BITS-1:0] len_fix;

  assign rem_sh  = {rem_q, rad_q[SQ_BITS-1 -: 2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign root_ok = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;
  assign len_fix = root_q + DELTA_BITS'(rem_q != '0);

  // per-pixel division of |delta * t| by the step count
  logic [SQ_BITS-1:0]    mag_x, mag_y;
  logic [DELTA_BITS-1:0] quo_x, quo_y;

  assign mag_x = SQ_BITS'(acc_x_q[ACC_BITS-1] ? -acc_x_q : acc_x_q);
  assign mag_y = SQ_BITS'(acc_y_q[ACC_BITS-1] ? -acc_y_q : acc_y_q);

  plr_div u_div_x (
    .clk_i      (clk_i),
    .start_i    (cmd_i.div_start),
    .step_i     (cmd_i.div_step),
    .dividend_i (mag_x),
    .divisor_i  (step_total_q),
    .quotient_o (quo_x)
  );

  plr_div u_div_y (
    .clk_i      (clk_i),
    .start_i    (cmd_i.div_start),
    .step_i     (cmd_i.div_step),
    .dividend_i (mag_y),
    .divisor_i  (step_total_q),
    .quotient_o (quo_y)
  );

  // pixel position and flags
  logic [DELTA_BITS-1:0]     qx_mag, qy_mag;
  logic signed [PX_BITS-1:0] qx_s, qy_s, px, py;
  logic                      in_x, in_y, fin;

  assign qx_mag = (step_total_q == '0) ? '0 : quo_x;
  assign qy_mag = (step_total_q == '0) ? '0 : quo_y;
  assign qx_s   = acc_x_q[ACC_BITS-1] ? -$signed({1'b0, qx_mag}) : $signed({1'b0, qx_mag});
  assign qy_s   = acc_y_q[ACC_BITS-1] ? -$signed({1'b0, qy_mag}) : $signed({1'b0, qy_mag});
  assign px     = PX_BITS'(origin_x_q) + qx_s;
  assign py     = PX_BITS'(origin_y_q) + qy_s;
  assign in_x   = !px[PX_BITS-1] &&
                  ($unsigned(CMP_BITS'(px)) < CMP_BITS'(surf_width_q));
  assign in_y   = !py[PX_BITS-1] &&
                  ($unsigned(CMP_BITS'(py)) < CMP_BITS'(surf_height_q));
  assign fin    = step_index_q >= step_total_q;

  always_comb begin
    busy_d = busy_q;
    if (cmd_i.load) begin
      busy_d = 1'b1;
    end else if (cmd_i.emit && fin) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= 1'b0;
      surf_width_q  <= SURF_WIDTH_RST;
      surf_height_q <= SURF_HEIGHT_RST;
    end else begin
      busy_q <= busy_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_SURF_WIDTH:  surf_width_q  <= cfg_wdata_i;
          CFG_SURF_HEIGHT: surf_height_q <= cfg_wdata_i;
          default:         surf_width_q  <= surf_width_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      origin_x_q   <= in_word_i.x_start;
      origin_y_q   <= in_word_i.y_start;
      delta_x_q    <= dx_load;
      delta_y_q    <= dy_load;
      held_rgb_q   <= in_word_i.rgb;
      step_index_q <= '0;
      acc_x_q      <= '0;
      acc_y_q      <= '0;
    end
    if (cmd_i.square) begin
      sq_x_q <= SQ_BITS'(delta_x_q) * SQ_BITS'(delta_x_q);
      sq_y_q <= SQ_BITS'(delta_y_q) * SQ_BITS'(delta_y_q);
    end
    if (cmd_i.sum) begin
      rad_q  <= sq_x_q + sq_y_q;
      rem_q  <= '0;
      root_q <= '0;
    end
    if (cmd_i.root_step) begin
      rad_q  <= {rad_q[SQ_BITS-3:0], 2'b00};
      rem_q  <= root_ok ? rem_sub[DELTA_BITS:0] : rem_sh[DELTA_BITS:0];
      root_q <= {root_q[DELTA_BITS-2:0], root_ok};
    end
    if (cmd_i.root_fix) begin
      step_total_q <= len_fix;
    end
    if (cmd_i.emit) begin
      out_word_q.pixel_x    <= px[COORD_BITS-1:0];
      out_word_q.pixel_y    <= py[COORD_BITS-1:0];
      out_word_q.pixel_rgb  <= held_rgb_q;
      out_word_q.inside_res <= in_x && in_y;
      out_word_q.last       <= fin;
      if (!fin) begin
        // advance t and the running products delta * t
        step_index_q <= DELTA_BITS'(step_index_q + 1'b1);
        acc_x_q      <= acc_x_q + ACC_BITS'(delta_x_q);
        acc_y_q      <= acc_y_q + ACC_BITS'(delta_y_q);
      end
    end
  end

  assign status_o.busy = busy_q;
  assign out_word_o    = out_word_q;

endmodule

### sv/parametric_line_rasterizer_unit.sv
// Channel  Direction  Handshake              Word
// in       input      in_valid_i/in_ready_o  in_word_i   (load or step request)
// out      output     out_valid_o/out_ready_i out_word_o (one pixel)
// cfg      input      cfg_we_i               cfg_addr_i, cfg_wdata_i (surface size)
//
// A step word is accepted, then runs through the two restoring dividers
// (one quotient bit each per step, x and y side by side), then emits a pixel.
// A load word runs accept, square, sum, the square-root steps, then fix.
// A step while no line is held is taken and dropped.
// Reset (rst_ni low, asynchronous) idles the block and sets the surface to
// 640 x 480. A stalled out channel holds the block in its emit cycle only
// when a pixel still waits in the output register.
module parametric_line_rasterizer_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  plr_pkg::in_word_t            in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output plr_pkg::out_word_t           out_word_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_addr_i,
  input  logic [plr_pkg::CFG_BITS-1:0] cfg_wdata_i
);
  import plr_pkg::*;

  `include "parametric_line_rasterizer_unit_assert.svh"

  // Command and status between the sequencer and the arithmetic.
  plr_cmd_t    cmd;
  plr_status_t status;

  // Sequencer: owns the state, the iteration count and the out valid flag.
  plr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_func_i   (in_word_i.func),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // Datapath: line registers, square root, dividers, clipping, output word.
  plr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_word_o  (out_word_o)
  );

  // A word taken with no line held either opens a line or is dropped with
  // the block left ready.
  `PLR_ASSERT_NEXT(a_idle_step, in_valid_i && in_ready_o && !status.busy, in_ready_o || status.busy)
  // Write the output register only when its previous word is gone.
  `PLR_ASSERT_SAME(a_emit_slot_free, cmd.emit, !out_valid_o || out_ready_i)
  // A load leaves a line held.
  `PLR_ASSERT_NEXT(a_load_sets_busy, cmd.load, status.busy)
  // Never iterate the dividers or the square root while taking words.
  `PLR_ASSERT_SAME(a_ready_not_dividing, in_ready_o, !cmd.div_step && !cmd.root_step)

endmodule

### bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import plr_pkg::*;

  // Pause after the last pixel before a register write: a load emits
  // nothing and keeps the block busy through square, sum, root and fix.
  localparam int unsigned QUIET_CYCLES   = 32;
  // Long hold on the out channel; once a pixel waits in the output register,
  // the next step stalls in S_EMIT and in_ready_o drops well within this stretch.
  localparam int unsigned SQUEEZE_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT    = 400000;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_word_t            in_word_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_word_t           out_word_o;
  logic                cfg_we_i    = 1'b0;
  logic                cfg_addr_i  = CFG_SURF_WIDTH;
  logic [CFG_BITS-1:0] cfg_wdata_i = '0;

  parametric_line_rasterizer_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // --------------------------------------------------------------------
  // Shadow of the line engine: surface size, the held line and its cursor.
  // --------------------------------------------------------------------
  logic [CFG_BITS-1:0]          surf_w_q = SURF_WIDTH_RST;
  logic [CFG_BITS-1:0]          surf_h_q = SURF_HEIGHT_RST;
  logic signed [COORD_BITS-1:0] line_ox = '0;
  logic signed [COORD_BITS-1:0] line_oy = '0;
  logic signed [DELTA_BITS-1:0] line_dx = '0;
  logic signed [DELTA_BITS-1:0] line_dy = '0;
  logic [DELTA_BITS-1:0]        line_total = '0;
  logic [DELTA_BITS-1:0]        line_index = '0;
  logic [RGB_BITS-1:0]          line_rgb = '0;
  bit                           line_busy = 1'b0;

  // Pixels still owed by the block, oldest first.
  out_word_t pixel_q[$];

  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t want;
  } dir_row_t;
  dir_row_t dir_tab[$];

  int unsigned mismatch_count = 0;
  int unsigned words_sent     = 0;
  int unsigned loads_sent     = 0;
  int unsigned idle_steps     = 0;
  int unsigned pixels_seen    = 0;
  int unsigned pixels_inside  = 0;
  int unsigned surfaces_set   = 0;
  int unsigned cycle_count    = 0;
  int unsigned in_stalls      = 0;
  bit          send_burst     = 1'b0;
  bit          take_burst     = 1'b0;
  bit          squeeze_req    = 1'b0;

  // Clock: 2 ns period.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (in_valid_i && !in_ready_o) in_stalls++;
  end

  // Watchdog.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: timeout after %0d cycles, %0d pixels outstanding",
             cycle_count, pixel_q.size());
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("tb: mismatch on %s at cycle %0d: got %0d, want %0d",
               what, cycle_count, got, want);
  endtask

  // Smallest r with r*r >= v; build the floor root bit by bit, then round up.
  function automatic longint unsigned ceil_root(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    for (int k = 17; k >= 0; k--) begin
      b = r | (64'd1 << k);
      if (b * b <= v) r = b;
    end
    if (r * r < v) r++;
    return r;
  endfunction

  // Advance the shadow by one accepted word; return 1 with the pixel it
  // must produce, or 0 when the word produces nothing.
  function automatic bit predict_pixel(input in_word_t w, output out_word_t px);
    longint sq;
    longint ax;
    longint ay;
    bit     fin;
    px = '0;
    if (w.func == FUNC_LOAD) begin
      line_ox    = w.x_start;
      line_oy    = w.y_start;
      line_dx    = DELTA_BITS'(longint'($signed(w.x_end)) - longint'($signed(w.x_start)));
      line_dy    = DELTA_BITS'(longint'($signed(w.y_end)) - longint'($signed(w.y_start)));
      sq         = longint'(line_dx) * longint'(line_dx) + longint'(line_dy) * longint'(line_dy);
      line_total = DELTA_BITS'(ceil_root(sq));
      line_index = '0;
      line_rgb   = w.rgb;
      line_busy  = 1'b1;
      return 1'b0;
    end
    if (!line_busy) return 1'b0;
    fin = (line_index >= line_total);
    ax  = longint'(line_ox);
    ay  = longint'(line_oy);
    // Signed division truncates toward zero, as the hardware must.
    if (line_total != 0) begin
      ax += (longint'(line_dx) * longint'(line_index)) / longint'(line_total);
      ay += (longint'(line_dy) * longint'(line_index)) / longint'(line_total);
    end
    px.pixel_x    = COORD_BITS'(ax);
    px.pixel_y    = COORD_BITS'(ay);
    px.pixel_rgb  = line_rgb;
    px.inside_res = (ax >= 0) && (ay >= 0) &&
                    (ax < longint'(surf_w_q)) && (ay < longint'(surf_h_q));
    px.last       = fin;
    if (fin) line_busy = 1'b0;
    else line_index++;
    return 1'b1;
  endfunction

  function automatic in_word_t rand_word(func_e f);
    logic [95:0] bits_r;
    in_word_t    w;
    bits_r = {$urandom(), $urandom(), $urandom()};
    w      = bits_r[$bits(in_word_t)-1:0];
    w.func = f;
    return w;
  endfunction

  function automatic dir_row_t row(func_e f, int xs = 0, int ys = 0, int xe = 0, int ye = 0,
                                   int unsigned rgb = 0, bit typed = 1'b0,
                                   int px = 0, int py = 0, int unsigned prgb = 0,
                                   bit ins = 1'b0, bit lst = 1'b0);
    dir_row_t r;
    r.word              = '0;
    r.word.func         = f;
    r.word.x_start      = COORD_BITS'(xs);
    r.word.y_start      = COORD_BITS'(ys);
    r.word.x_end        = COORD_BITS'(xe);
    r.word.y_end        = COORD_BITS'(ye);
    r.word.rgb          = RGB_BITS'(rgb);
    r.typed             = typed;
    r.want.pixel_x      = COORD_BITS'(px);
    r.want.pixel_y      = COORD_BITS'(py);
    r.want.pixel_rgb    = RGB_BITS'(prgb);
    r.want.inside_res   = ins;
    r.want.last         = lst;
    return r;
  endfunction

  // Pick a coordinate on one axis: near zero, near the far edge of the
  // surface, somewhere on it, or anywhere short of wrapping a short line.
  function automatic int pick_axis(int extent);
    case ($urandom_range(0, 3))
      0:       return int'($urandom_range(0, 32)) - 16;
      1:       return extent + int'($urandom_range(0, 32)) - 16;
      2:       return int'($urandom_range(0, extent > 0 ? extent - 1 : 0));
      default: return int'($urandom_range(0, 64000)) - 32000;
    endcase
  endfunction

  // Offer one word on the in channel after a random gap, wait for the
  // handshake, then book the pixel it owes. Valid stays high on return so
  // that a back-to-back word never drops it.
  task automatic send_word(input in_word_t w, input bit typed = 1'b0,
                           input out_word_t want = '0);
    out_word_t   px;
    int unsigned gap;
    bit          has;
    if ($urandom_range(0, 23) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 15);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    has = predict_pixel(w, px);
    if (has) pixel_q = {pixel_q, (typed ? want : px)};
    if (w.func == FUNC_LOAD) loads_sent++;
    if (w.func == FUNC_LOAD || has) words_sent++;
    else idle_steps++;
  endtask

  // Drop valid, wait out every owed pixel, then give a trailing load time
  // to finish before anything touches the registers.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_surface(int unsigned w, int unsigned h);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CFG_SURF_WIDTH;
    cfg_wdata_i <= CFG_BITS'(w);
    @(negedge clk_i);
    cfg_addr_i  <= CFG_SURF_HEIGHT;
    cfg_wdata_i <= CFG_BITS'(h);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    surf_w_q = CFG_BITS'(w);
    surf_h_q = CFG_BITS'(h);
    surfaces_set++;
  endtask

  // Mostly whole short lines starting near the surface edges, on the surface
  // or anywhere; the rest are full-range lines cut after a few pixels, zero
  // length lines, stray steps and lines broken off early.
  task automatic run_phase(int unsigned count, bit squeeze);
    in_word_t    w;
    int unsigned stop;
    int unsigned n;
    int          x0;
    int          y0;
    stop = words_sent + count;
    if (squeeze) begin
      // A 50-step line; ask the receiver to hold off while it streams.
      w         = rand_word(FUNC_LOAD);
      w.x_start = COORD_BITS'(100);
      w.y_start = COORD_BITS'(100);
      w.x_end   = COORD_BITS'(140);
      w.y_end   = COORD_BITS'(130);
      send_word(w);
      squeeze_req = 1'b1;
      repeat (int'(line_total) + 1) send_word(rand_word(FUNC_STEP));
    end
    while (words_sent < stop) begin
      w = rand_word(FUNC_LOAD);
      case ($urandom_range(0, 19))
        0, 1: begin
          // Full-range endpoints: take a few pixels, the next load drops it.
          send_word(w);
          n = $urandom_range(1, 6);
        end
        2: begin
          w.x_end = w.x_start;
          w.y_end = w.y_start;
          send_word(w);
          n = $urandom_range(1, 2);
        end
        3: n = 1;
        default: begin
          x0        = pick_axis(int'(surf_w_q));
          y0        = pick_axis(int'(surf_h_q));
          w.x_start = COORD_BITS'(x0);
          w.y_start = COORD_BITS'(y0);
          w.x_end   = COORD_BITS'(x0 + int'($urandom_range(0, 24)) - 12);
          w.y_end   = COORD_BITS'(y0 + int'($urandom_range(0, 24)) - 12);
          send_word(w);
          n = int'(line_total) + 1;
          if ($urandom_range(0, 7) == 0) n = $urandom_range(0, n - 1);
          else if ($urandom_range(0, 3) == 0) n++;
        end
      endcase
      repeat (n) send_word(rand_word(FUNC_STEP));
    end
  endtask

  // Receiver: random gaps per word, bursts of no gaps, and one long
  // hold-off when the sender asks for it.
  initial begin
    int unsigned gap;
    int unsigned held;
    @(posedge rst_ni);
    forever begin
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        held = 0;
        while (held < SQUEEZE_CYCLES) begin
          @(negedge clk_i);
          out_ready_i <= 1'b0;
          held++;
        end
      end
      if ($urandom_range(0, 23) == 0) take_burst = !take_burst;
      gap = take_burst ? 0 : $urandom_range(0, 15);
      repeat (gap) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Check every pixel taken off the out channel against the oldest one owed.
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      pixels_seen++;
      if (out_word_o.inside_res) pixels_inside++;
      if (pixel_q.size() == 0) begin
        report_mismatch("unexpected pixel x", out_word_o.pixel_x, 0);
      end else begin
        want = pixel_q.pop_front();
        if (out_word_o.pixel_x !== want.pixel_x)
          report_mismatch("pixel_x", out_word_o.pixel_x, want.pixel_x);
        if (out_word_o.pixel_y !== want.pixel_y)
          report_mismatch("pixel_y", out_word_o.pixel_y, want.pixel_y);
        if (out_word_o.pixel_rgb !== want.pixel_rgb)
          report_mismatch("pixel_rgb", out_word_o.pixel_rgb, want.pixel_rgb);
        if (out_word_o.inside_res !== want.inside_res)
          report_mismatch("inside_res", out_word_o.inside_res, want.inside_res);
        if (out_word_o.last !== want.last)
          report_mismatch("last", out_word_o.last, want.last);
      end
    end
  end

  initial begin
    // Directed words under the reset surface of 640 x 480. Typed pixels are
    // the ones that can be read straight off the endpoints.
    dir_tab = '{
      row(FUNC_STEP),                                          // no line held: drop
      row(FUNC_LOAD, 0, 0, 0, 0, 'hFFFFFF),                   // zero length
      row(FUNC_STEP, 0, 0, 0, 0, 0, 1'b1, 0, 0, 'hFFFFFF, 1'b1, 1'b1),
      row(FUNC_STEP),                                          // line done: drop
      row(FUNC_LOAD, -32768, -32768, 32767, 32767, 'h000000),
      row(FUNC_STEP, 0, 0, 0, 0, 0, 1'b1, -32768, -32768, 'h000000, 1'b0, 1'b0),
      row(FUNC_STEP),
      // Load while a line is open: the old one is dropped.
      row(FUNC_LOAD, 32767, 32767, -32768, -32768, 'hA5A5A5),
      row(FUNC_STEP, 0, 0, 0, 0, 0, 1'b1, 32767, 32767, 'hA5A5A5, 1'b0, 1'b0),
      row(FUNC_STEP),
      // Corners of the surface: last pixel inside, one past it outside.
      row(FUNC_LOAD, 639, 479, 639, 479, 'h123456),
      row(FUNC_STEP, 0, 0, 0, 0, 0, 1'b1, 639, 479, 'h123456, 1'b1, 1'b1),
      row(FUNC_LOAD, 640, 479, 640, 479, 'h5A5A5A),
      row(FUNC_STEP, 0, 0, 0, 0, 0, 1'b1, 640, 479, 'h5A5A5A, 1'b0, 1'b1),
      row(FUNC_LOAD, 0, 480, 0, 480, 'h0F0F0F),
      row(FUNC_STEP, 0, 0, 0, 0, 0, 1'b1, 0, 480, 'h0F0F0F, 1'b0, 1'b1),
      // Negative deltas: quotients truncate toward zero, not down.
      row(FUNC_LOAD, 10, 10, 7, 6, 'h00FF00),
      row(FUNC_STEP), row(FUNC_STEP), row(FUNC_STEP),
      row(FUNC_STEP), row(FUNC_STEP), row(FUNC_STEP),
      // Crossing the origin; left open and dropped by the next load.
      row(FUNC_LOAD, -2, -1, 2, 1, 'hFF0000),
      row(FUNC_STEP), row(FUNC_STEP), row(FUNC_STEP)
    };

    // Hold reset, then release it on a falling edge.
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) send_word(dir_tab[i].word, dir_tab[i].typed, dir_tab[i].want);

    // Random phases, one surface setting each, extremes included.
    settle();
    set_surface(4096, 4096);
    run_phase(140, 1'b1);
    settle();
    set_surface(1, 1);
    run_phase(90, 1'b0);
    settle();
    set_surface(8191, 0);
    run_phase(90, 1'b0);
    settle();
    set_surface(0, 8191);
    run_phase(90, 1'b0);
    settle();
    set_surface($urandom_range(1, 4096), $urandom_range(1, 4096));
    run_phase(170, 1'b0);
    settle();

    if (pixel_q.size() != 0) report_mismatch("pixels never emitted", pixel_q.size(), 0);

    $display("tb: %0d words (%0d loads), %0d idle steps, %0d pixels checked, %0d inside",
             words_sent, loads_sent, idle_steps, pixels_seen, pixels_inside);
    $display("tb: %0d surface sizes written, in channel stalled %0d of %0d cycles",
             surfaces_set, in_stalls, cycle_count);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/plr_pkg.sv
sv/plr_div.sv
sv/plr_ctrl.sv
sv/plr_dp.sv
sv/parametric_line_rasterizer_unit.sv
bench/tb_top.sv
